/* rtl/ple_pkg.sv */
package ple_pkg;

  localparam int LIST_DEPTH_DEF = 16;

  localparam int KIND_W  = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_DEL_FRONT = 3'd2,
    KIND_DEL_BACK  = 3'd3,
    KIND_INS_AT    = 3'd4,
    KIND_DEL_AT    = 3'd5
  } kind_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } shift_t;

endpackage

/* rtl/ple_cell.sv */
module ple_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  ple_pkg::shift_t                   shift,
  input  logic [IDX_W-1:0]                  slot,
  input  logic [IDX_W-1:0]                  tail,
  input  logic signed [ple_pkg::VAL_W-1:0]  new_value,
  input  logic signed [ple_pkg::VAL_W-1:0]  left_in,
  input  logic signed [ple_pkg::VAL_W-1:0]  right_in,
  output logic signed [ple_pkg::VAL_W-1:0]  data_out,
  output logic signed [ple_pkg::VAL_W-1:0]  removed_part,
  output logic signed [ple_pkg::VAL_W-1:0]  tail_part
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    at_slot;
  logic                    above_slot;

  always_comb begin
    at_slot    = (MY_IDX == slot);
    above_slot = (MY_IDX > slot);
    priority if (shift.ins && at_slot) begin
      data_nxt = new_value;
    end else if (shift.ins && above_slot) begin
      data_nxt = left_in;
    end else if (shift.del && (at_slot || above_slot)) begin
      data_nxt = right_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out     = data_r;
  assign removed_part = at_slot ? data_r : '0;
  assign tail_part    = (MY_IDX == tail) ? data_nxt : '0;

endmodule

/* rtl/ple_ctrl.sv */
module ple_ctrl #(
  parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEF,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1),
  parameter int IDX_W      = $clog2(LIST_DEPTH)
) (
  input  logic [ple_pkg::KIND_W-1:0] kind,
  input  logic [ple_pkg::POS_W-1:0]  position,
  input  logic [CNT_W-1:0]           count,
  output ple_pkg::shift_t            shift,
  output ple_pkg::status_t           status,
  output logic [IDX_W-1:0]           slot,
  output logic [IDX_W-1:0]           tail,
  output logic [CNT_W-1:0]           count_nxt
);
  import ple_pkg::*;

  localparam int W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [W-1:0] pos_w;
  logic [W-1:0] cnt_w;
  logic [W-1:0] slot_w;
  logic [W-1:0] cnt_nxt_w;
  logic         full;
  logic         empty;
  logic         pos_zero;

  always_comb begin
    pos_w    = W'(position);
    cnt_w    = W'(count);
    full     = (cnt_w == W'(LIST_DEPTH));
    empty    = (cnt_w == '0);
    pos_zero = (pos_w == '0);
    shift    = '0;
    status   = ST_OK;
    slot_w   = '0;
    unique case (kind)
      KIND_INS_FRONT: begin
        if (full) status = ST_FULL;
        else shift.ins = 1'b1;
      end
      KIND_INS_BACK: begin
        slot_w = cnt_w;
        if (full) status = ST_FULL;
        else shift.ins = 1'b1;
      end
      KIND_DEL_FRONT: begin
        if (empty) status = ST_EMPTY;
        else shift.del = 1'b1;
      end
      KIND_DEL_BACK: begin
        slot_w = cnt_w - W'(1);
        if (empty) status = ST_EMPTY;
        else shift.del = 1'b1;
      end
      KIND_INS_AT: begin
        slot_w = pos_w - W'(1);
        priority if (pos_zero || pos_w > cnt_w + W'(1)) status = ST_BADPOS;
        else if (full) status = ST_FULL;
        else shift.ins = 1'b1;
      end
      KIND_DEL_AT: begin
        slot_w = pos_w - W'(1);
        priority if (empty) status = ST_EMPTY;
        else if (pos_zero || pos_w > cnt_w) status = ST_BADPOS;
        else shift.del = 1'b1;
      end
      default: status = ST_BADPOS;
    endcase

    priority if (shift.ins) cnt_nxt_w = cnt_w + W'(1);
    else if (shift.del) cnt_nxt_w = cnt_w - W'(1);
    else cnt_nxt_w = cnt_w;

    slot      = slot_w[IDX_W-1:0];
    count_nxt = cnt_nxt_w[CNT_W-1:0];
    tail      = IDX_W'(cnt_nxt_w - W'(1));
  end

endmodule

/* rtl/positional_list_engine_unit.sv */
// Bounded ordered list of signed 32-bit values, one value per cell in a row
// of LIST_DEPTH cells. Each input word is a command: insert at front/back,
// delete front/back, insert at or delete at a 1-based position. The cells
// after the target slot all shift by one place in the same clock.
// Input channel in_*: tdata = {position, value, kind}. Result channel out_*:
// tdata = {pad, last, first, removed, entry_total, status}; one result word
// per command, in command order.
// The result word is loaded into the output register as the command is
// accepted. Throughput: one command per cycle as long as the result side
// keeps taking words; the cell row does any shift in the same clock as the
// accept, so the output register is the only limit.
// Stall: while a result word waits with out_tready low, in_tready is low;
// it goes high in the same cycle the waiting word is taken.
// Reset (rst_n low, synchronous): the list is emptied and the output
// register is marked empty. Cell contents are not cleared; slots beyond the
// entry count are never reported.
module positional_list_engine_unit #(
  parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] kind, [34:3] value, [39:35] position
  input  logic [ple_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [6:2] entry_total, [38:7] removed_value,
  // [70:39] first_value, [102:71] last_value, [103] zero
  output logic [ple_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int EXT_W = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

  logic                    accept;
  logic [KIND_W-1:0]       kind;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [EXT_W-1:0]        count_ext;
  shift_t                  shift_dec;
  shift_t                  shift;
  status_t                 status;
  logic [IDX_W-1:0]        slot;
  logic [IDX_W-1:0]        tail;

  logic signed [VAL_W-1:0] cell_q       [LIST_DEPTH];
  logic signed [VAL_W-1:0] removed_part [LIST_DEPTH];
  logic signed [VAL_W-1:0] tail_part    [LIST_DEPTH];
  logic signed [VAL_W-1:0] removed_or;
  logic signed [VAL_W-1:0] tail_or;
  logic signed [VAL_W-1:0] first_val;
  logic signed [VAL_W-1:0] last_val;
  logic signed [VAL_W-1:0] removed_val;

  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  assign kind     = in_tdata[2:0];
  assign value    = in_tdata[34:3];
  assign position = in_tdata[39:35];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  ple_ctrl #(
    .LIST_DEPTH(LIST_DEPTH),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .kind     (kind),
    .position (position),
    .count    (count_r),
    .shift    (shift_dec),
    .status   (status),
    .slot     (slot),
    .tail     (tail),
    .count_nxt(count_nxt)
  );

  always_comb begin
    shift.ins = shift_dec.ins && accept;
    shift.del = shift_dec.del && accept;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_in;
    logic signed [VAL_W-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_body
      assign left_in = cell_q[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid
      assign right_in = cell_q[i+1];
    end
    ple_cell #(
      .IDX_W(IDX_W),
      .IDX  (i)
    ) u_cell (
      .clk         (clk),
      .shift       (shift),
      .slot        (slot),
      .tail        (tail),
      .new_value   (value),
      .left_in     (left_in),
      .right_in    (right_in),
      .data_out    (cell_q[i]),
      .removed_part(removed_part[i]),
      .tail_part   (tail_part[i])
    );
  end

  // each cell drives zero unless it is the selected slot (removed) or the new tail (tail)
  always_comb begin
    removed_or = '0;
    tail_or    = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      removed_or = removed_or | removed_part[i];
      tail_or    = tail_or | tail_part[i];
    end
  end

  always_comb begin
    count_ext   = EXT_W'(count_nxt);
    removed_val = shift_dec.del ? removed_or : '0;
    if (count_nxt == '0) begin
      first_val = '0;
      last_val  = '0;
    end else begin
      priority if (shift_dec.ins && slot == '0) first_val = value;
      else if (shift_dec.del && slot == '0) first_val = cell_q[1];
      else first_val = cell_q[0];
      last_val = tail_or;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {1'b0, last_val, first_val, removed_val,
                     count_ext[TOTAL_W-1:0], status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
